// ===== sv/aids_pkg.sv =====
// Shared types and codes for the packed array with insert, delete and search.
`timescale 1ns / 1ps
`default_nettype none

package aids_pkg;

  typedef enum logic [2:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_SEARCH = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  localparam int unsigned CmdW   = 3;
  localparam int unsigned PosW   = 7;
  localparam int unsigned ValW   = 32;
  localparam int unsigned CountW = 8;

  typedef struct packed {
    logic [CountW-1:0] entry_count;
    logic [ValW-1:0]   read_value;
    logic [PosW-1:0]   found_index;
    status_e           status;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/aids_ram.sv =====
// Entry store: one write port and one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module aids_ram
  import aids_pkg::*;
#(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [AW-1:0]   waddr_i,
  input  wire logic [ValW-1:0] wdata_i,
  input  wire logic [AW-1:0]   raddr_i,
  output logic      [ValW-1:0] rdata_o
);

  logic [ValW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== sv/aids_seq.sv =====
// Command sequencer: decodes a word, walks the store for shifts and searches.
`timescale 1ns / 1ps
`default_nettype none

module aids_seq
  import aids_pkg::*;
#(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7,
  parameter int unsigned CW    = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [CmdW-1:0] cmd_i,
  input  wire logic [PosW-1:0] pos_i,
  input  wire logic [ValW-1:0] val_i,
  output logic                 res_valid_o,
  input  wire logic            res_ready_i,
  output res_t                 res_o,
  output logic                 mem_we_o,
  output logic      [AW-1:0]   mem_waddr_o,
  output logic      [ValW-1:0] mem_wdata_o,
  output logic      [AW-1:0]   mem_raddr_o,
  input  wire logic [ValW-1:0] mem_rdata_i
);

  localparam int unsigned PCW = (CW > PosW) ? CW : PosW;

  typedef enum logic [2:0] {
    S_IDLE, S_UP, S_DOWN, S_FIN, S_PUT, S_SRCH, S_READ, S_DONE
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   count_q;
  logic [AW-1:0]   ptr_q, lim_q, pos_q, pa_q, fnd_q;
  logic            pv_q, iss_q, ins_q;
  logic [ValW-1:0] val_q, rd_q;
  status_e         st_q;

  logic [PCW-1:0]  pos_w, cnt_w;
  logic [AW-1:0]   pos_a;
  logic            full;
  logic            accept;

  assign pos_w  = PCW'(pos_i);
  assign cnt_w  = PCW'(count_q);
  assign pos_a  = AW'(pos_i);
  assign full   = (count_q == CW'(DEPTH));
  assign accept = in_valid_i && (state_q == S_IDLE);

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_o.status      = st_q;
    res_o.found_index = PosW'(fnd_q);
    res_o.read_value  = rd_q;
    res_o.entry_count = CountW'(count_q);
  end

  // The write port either drains the word read in the previous cycle during a
  // shift, or stores a new value on append, insert at the end, or insert.
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = pa_q;
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = ptr_q;
    unique case (state_q)
      S_UP, S_DOWN, S_FIN: begin
        mem_we_o = pv_q;
      end
      S_PUT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = pos_q;
        mem_wdata_o = val_q;
      end
      S_IDLE: begin
        mem_raddr_o = pos_a;
        mem_waddr_o = AW'(count_q);
        mem_wdata_o = val_i;
        if (accept && !full) begin
          if (cmd_e'(cmd_i) == CMD_APPEND) begin
            mem_we_o = 1'b1;
          end else if (cmd_e'(cmd_i) == CMD_INSERT && pos_w == cnt_w) begin
            mem_we_o = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ptr_q   <= '0;
      lim_q   <= '0;
      pos_q   <= '0;
      pa_q    <= '0;
      fnd_q   <= '0;
      pv_q    <= 1'b0;
      iss_q   <= 1'b0;
      ins_q   <= 1'b0;
      val_q   <= '0;
      rd_q    <= '0;
      st_q    <= ST_OK;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            st_q    <= ST_OK;
            fnd_q   <= '0;
            rd_q    <= '0;
            pos_q   <= pos_a;
            val_q   <= val_i;
            pv_q    <= 1'b0;
            ins_q   <= 1'b0;
            state_q <= S_DONE;
            unique case (cmd_e'(cmd_i))
              CMD_APPEND: begin
                if (full) begin
                  st_q <= ST_FULL;
                end else begin
                  count_q <= count_q + CW'(1);
                end
              end
              CMD_INSERT: begin
                if (full) begin
                  st_q <= ST_FULL;
                end else if (pos_w > cnt_w) begin
                  st_q <= ST_RANGE;
                end else begin
                  count_q <= count_q + CW'(1);
                  ins_q   <= 1'b1;
                  ptr_q   <= AW'(count_q - CW'(1));
                  if (pos_w != cnt_w) begin
                    state_q <= S_UP;
                  end
                end
              end
              CMD_DELETE: begin
                if (pos_w >= cnt_w) begin
                  st_q <= ST_RANGE;
                end else begin
                  count_q <= count_q - CW'(1);
                  ptr_q   <= AW'(pos_a + AW'(1));
                  lim_q   <= AW'(count_q - CW'(1));
                  if (cnt_w != PCW'(pos_w + PCW'(1))) begin
                    state_q <= S_DOWN;
                  end
                end
              end
              CMD_SEARCH: begin
                if (count_q == '0) begin
                  st_q <= ST_MISS;
                end else begin
                  ptr_q   <= '0;
                  lim_q   <= AW'(count_q - CW'(1));
                  iss_q   <= 1'b1;
                  state_q <= S_SRCH;
                end
              end
              CMD_READ: begin
                if (pos_w >= cnt_w) begin
                  st_q <= ST_RANGE;
                end else begin
                  state_q <= S_READ;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_UP: begin
          pv_q <= 1'b1;
          pa_q <= AW'(ptr_q + AW'(1));
          if (ptr_q == pos_q) begin
            state_q <= S_FIN;
          end else begin
            ptr_q <= AW'(ptr_q - AW'(1));
          end
        end
        S_DOWN: begin
          pv_q <= 1'b1;
          pa_q <= AW'(ptr_q - AW'(1));
          if (ptr_q == lim_q) begin
            state_q <= S_FIN;
          end else begin
            ptr_q <= AW'(ptr_q + AW'(1));
          end
        end
        S_FIN: begin
          pv_q    <= 1'b0;
          state_q <= ins_q ? S_PUT : S_DONE;
        end
        S_PUT: begin
          state_q <= S_DONE;
        end
        S_SRCH: begin
          // Reads are issued one per cycle; each word is compared in the cycle after its read.
          pv_q <= iss_q;
          pa_q <= ptr_q;
          if (iss_q) begin
            if (ptr_q == lim_q) begin
              iss_q <= 1'b0;
            end else begin
              ptr_q <= AW'(ptr_q + AW'(1));
            end
          end
          if (pv_q && mem_rdata_i == val_q) begin
            fnd_q   <= pa_q;
            st_q    <= ST_OK;
            pv_q    <= 1'b0;
            iss_q   <= 1'b0;
            state_q <= S_DONE;
          end else if (pv_q && pa_q == lim_q) begin
            st_q    <= ST_MISS;
            pv_q    <= 1'b0;
            iss_q   <= 1'b0;
            state_q <= S_DONE;
          end
        end
        S_READ: begin
          rd_q    <= mem_rdata_i;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/array_insert_delete_search_top.sv =====
// Top level of the packed array with append, insert, delete, search and read.
//
// Input stream (s_axis_*): one word per command, taken when tvalid and tready
// are both high. Output stream (m_axis_*): exactly one result word per
// command, in command order, from an output register.
// Append, unused codes and insert at the end go straight to the result
// register; read first fetches the entry. Insert elsewhere moves entries from
// the last down to the position up one place, then writes the value; delete
// moves entries above the position down one place (none for the last entry).
// The store moves one entry per cycle through its single read and write port.
// Search compares one entry per cycle in store order, to a hit or the end.
// One command is worked on at a time; the next is taken once the result has
// moved into the output register, even if that word still waits there.
// Reset empties the array at once (count zero); entry contents are not
// cleared, since no entry at or beyond the count is ever read.
// When the receiver stalls the result word holds, and at most one further
// command is worked through before the input side stalls too.
`timescale 1ns / 1ps
`default_nettype none

module array_insert_delete_search_top
  import aids_pkg::*;
#(
  parameter int unsigned DEPTH = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // command [2:0], position [9:3], value [41:10], zero fill above
  input  wire logic [47:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // status [1:0], found_index [8:2], read_value [40:9], entry_count [48:41],
  // zero fill above
  output logic      [55:0] m_axis_tdata_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned ResW = $bits(res_t);

  logic            res_valid, res_ready;
  res_t            res;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [ValW-1:0] mem_wdata, mem_rdata;
  logic            m_valid_q;
  res_t            m_res_q;

  aids_seq #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .CW   (CW)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .cmd_i      (s_axis_tdata_i[CmdW-1:0]),
    .pos_i      (s_axis_tdata_i[CmdW+PosW-1:CmdW]),
    .val_i      (s_axis_tdata_i[CmdW+PosW+ValW-1:CmdW+PosW]),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  aids_ram #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // The output register frees the sequencer as soon as a word is parked here.
  assign res_ready = !m_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      m_res_q   <= '0;
    end else if (res_ready) begin
      m_valid_q <= res_valid;
      if (res_valid) begin
        m_res_q <= res;
      end
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(56 - ResW){1'b0}}, m_res_q};

endmodule

`default_nettype wire
